/* hdl/dmps_pkg.sv */
package dmps_pkg;

    localparam int BYTES_PER_FRAME = 512;
    localparam int BYTE_W          = 9;
    localparam int PIXELS          = 8;
    localparam int PIXEL_W         = 3;

    localparam int TAP_COUNT  = 24;
    localparam int TAP_W      = 5;
    localparam int WEIGHT_W   = 10;
    localparam int ACC_W      = 14;

    localparam int WEIGHT_SUM   = 9998;
    localparam int SHADE_SCALE  = 255;
    localparam int SHADE_SHIFT  = 4;
    localparam int SHADE_W      = 4;
    localparam int SHADE_LEVELS = 16;

    // floor(floor(255*acc/9998)/16) == floor(255*acc/(9998*16))
    localparam int ShadeDivisor = WEIGHT_SUM * (2 ** SHADE_SHIFT);

    localparam int HISTORY_FRAMES_DEF = 24;
    localparam int DISPLAY_COUNT_DEF  = 2;

    localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [TAP_COUNT] = '{
        10'd8,   10'd19,  10'd44,  10'd91,  10'd168, 10'd274, 10'd405, 10'd552,
        10'd699, 10'd830, 10'd928, 10'd981, 10'd981, 10'd928, 10'd830, 10'd699,
        10'd552, 10'd405, 10'd274, 10'd168, 10'd91,  10'd44,  10'd19,  10'd8
    };

    // smallest weight sum that reaches shade k
    function automatic logic [ACC_W-1:0] shade_threshold(input int unsigned k);
        return ACC_W'((k * ShadeDivisor + SHADE_SCALE - 1) / SHADE_SCALE);
    endfunction

    typedef struct packed {
        logic               display_select;
        logic [BYTE_W-1:0]  byte_index;
        logic [PIXELS-1:0]  pixel_byte;
        logic               frame_end;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte_index;
        logic [SHADE_W-1:0] shade_0;
        logic [SHADE_W-1:0] shade_1;
        logic [SHADE_W-1:0] shade_2;
        logic [SHADE_W-1:0] shade_3;
        logic [SHADE_W-1:0] shade_4;
        logic [SHADE_W-1:0] shade_5;
        logic [SHADE_W-1:0] shade_6;
        logic [SHADE_W-1:0] shade_7;
    } out_item_t;

endpackage

/* hdl/dmps_stream_if.sv */
interface dmps_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/dmps_ram.sv */
module dmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hdl/dot_matrix_pwm_shade_fir.sv */
// Temporal 24-tap low-pass shade recovery for two PWM-driven 128x32 dot-matrix
// displays. Each beat on pixels carries one byte (8 pixels) of the frame being
// written; it is stored in a ring history of HISTORY_FRAMES frames per display
// and one beat on shades returns the 4-bit shade of each of its 8 pixels. A
// beat is handled in order: the byte is stored, 23 older frames are read
// through the single history RAM port and the last read is drained, a bank
// of fixed threshold compares turns each pixel's weight sum into a shade one
// pixel after another, and the output register is loaded once it is free;
// pixels is not ready again until then.
// After reset the history RAM is cleared one byte a cycle, and pixels is
// not ready until the clear is done. frame_end advances the ring slot of its
// display after that beat's result is formed.
module dot_matrix_pwm_shade_fir import dmps_pkg::*; #(
    parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
    parameter int DISPLAY_COUNT  = DISPLAY_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dmps_stream_if.sink   pixels,
    dmps_stream_if.source shades
);

    localparam int FW    = $clog2(HISTORY_FRAMES);
    localparam int ROWS  = DISPLAY_COUNT * HISTORY_FRAMES;
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + BYTE_W;
    localparam int DEPTH = ROWS * BYTES_PER_FRAME;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_TAPS  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_CONV  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    function automatic logic [RW-1:0] row_of(input logic d, input logic [FW-1:0] f);
        return d ? RW'(f) + RW'(HISTORY_FRAMES) : RW'(f);
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [FW-1:0]       ring_slot_reg [DISPLAY_COUNT];
    logic [TAP_W-1:0]    tap_reg, tap_next;
    logic [TAP_W-1:0]    rd_tap_reg;
    logic                rd_valid_reg, rd_valid_next;
    logic [PIXEL_W-1:0]  pix_reg, pix_next;
    logic                out_valid_reg, out_valid_next;

    logic                disp_reg;
    logic [BYTE_W-1:0]   addr_reg;
    logic                fend_reg;
    logic [FW-1:0]       slot_reg;
    logic [FW-1:0]       fptr_reg, fptr_next;
    logic [ACC_W-1:0]    acc_reg [PIXELS];
    logic [ACC_W-1:0]    acc_next [PIXELS];
    logic [SHADE_W-1:0]  shade_reg [PIXELS];
    out_item_t           out_reg;

    logic                accept;
    logic                load;
    logic                disp_sel;
    logic [FW-1:0]       slot_cur;
    logic [FW-1:0]       slot_dec;
    logic [AW-1:0]       ram_addr;
    logic                ram_we;
    logic [PIXELS-1:0]   ram_wdata;
    logic [PIXELS-1:0]   ram_rdata;
    logic [ACC_W-1:0]    conv_acc;
    logic [SHADE_W-1:0]  conv_shade;

    assign pixels.ready = (state_reg == ST_IDLE);
    assign accept       = pixels.valid && pixels.ready;
    assign load         = (state_reg == ST_DONE) && (!out_valid_reg || shades.ready);
    assign disp_sel     = (DISPLAY_COUNT > 1) && pixels.data.display_select;
    assign slot_cur     = disp_sel ? ring_slot_reg[DISPLAY_COUNT-1] : ring_slot_reg[0];
    assign slot_dec     = (slot_cur == '0) ? FW'(HISTORY_FRAMES - 1) : slot_cur - 1'b1;

    assign shades.valid = out_valid_reg;
    assign shades.data  = out_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = pixels.data.pixel_byte;
        ram_addr  = {row_of(disp_reg, fptr_reg), addr_reg};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            ram_addr  = clr_addr_reg;
        end
        else if (accept)
        begin
            ram_we   = 1'b1;
            ram_addr = {row_of(disp_sel, slot_cur),
                        BYTE_W'(pixels.data.byte_index % BYTES_PER_FRAME)};
        end
    end

    dmps_ram #(
        .WIDTH (PIXELS),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_history (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // shade = number of thresholds reached
    assign conv_acc = acc_reg[pix_reg];
    always_comb
    begin
        conv_shade = '0;
        for (int k = 1; k < SHADE_LEVELS; k++)
        begin
            if (conv_acc >= shade_threshold(k))
            begin
                conv_shade = conv_shade + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        tap_next       = tap_reg;
        rd_valid_next  = (state_reg == ST_TAPS);
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg;
        fptr_next      = fptr_reg;

        if (out_valid_reg && shades.ready)
        begin
            out_valid_next = 1'b0;
        end

        for (int p = 0; p < PIXELS; p++)
        begin
            acc_next[p] = acc_reg[p];
            if (accept)
            begin
                acc_next[p] = pixels.data.pixel_byte[PIXELS-1-p]
                            ? ACC_W'(TAP_WEIGHT[0]) : '0;
            end
            else if (rd_valid_reg && ram_rdata[PIXELS-1-p])
            begin
                acc_next[p] = acc_reg[p] + ACC_W'(TAP_WEIGHT[rd_tap_reg]);
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    tap_next   = TAP_W'(1);
                    fptr_next  = slot_dec;
                    state_next = ST_TAPS;
                end
            end
            ST_TAPS:
            begin
                tap_next  = tap_reg + 1'b1;
                fptr_next = (fptr_reg == '0) ? FW'(HISTORY_FRAMES - 1) : fptr_reg - 1'b1;
                if (tap_reg == TAP_W'(TAP_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                pix_next   = '0;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                pix_next = pix_reg + 1'b1;
                if (pix_reg == PIXEL_W'(PIXELS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            tap_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < DISPLAY_COUNT; d++)
            begin
                ring_slot_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            tap_reg       <= tap_next;
            rd_valid_reg  <= rd_valid_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
            if (load && fend_reg)
            begin
                for (int d = 0; d < DISPLAY_COUNT; d++)
                begin
                    if ((d == DISPLAY_COUNT - 1) == disp_reg || DISPLAY_COUNT == 1)
                    begin
                        ring_slot_reg[d] <= (slot_reg == FW'(HISTORY_FRAMES - 1))
                                          ? '0 : slot_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tap_reg <= tap_reg;
        fptr_reg   <= fptr_next;
        for (int p = 0; p < PIXELS; p++)
        begin
            acc_reg[p] <= acc_next[p];
        end
        if (accept)
        begin
            disp_reg <= disp_sel;
            addr_reg <= BYTE_W'(pixels.data.byte_index % BYTES_PER_FRAME);
            fend_reg <= pixels.data.frame_end;
            slot_reg <= slot_cur;
        end
        if (state_reg == ST_CONV)
        begin
            shade_reg[pix_reg] <= conv_shade;
        end
        if (load)
        begin
            out_reg.out_byte_index <= addr_reg;
            out_reg.shade_0        <= shade_reg[0];
            out_reg.shade_1        <= shade_reg[1];
            out_reg.shade_2        <= shade_reg[2];
            out_reg.shade_3        <= shade_reg[3];
            out_reg.shade_4        <= shade_reg[4];
            out_reg.shade_5        <= shade_reg[5];
            out_reg.shade_6        <= shade_reg[6];
            out_reg.shade_7        <= shade_reg[7];
        end
    end

endmodule

/* tb/dot_matrix_pwm_shade_fir_tb.sv */
`timescale 1ns / 100ps

module dot_matrix_pwm_shade_fir_tb;
    import dmps_pkg::*;

    localparam int HIST_FRAMES = HISTORY_FRAMES_DEF;
    localparam int DISPLAYS    = DISPLAY_COUNT_DEF;
    localparam int BEAT_TARGET = 650;
    localparam int DIR_ROWS    = 20;
    localparam int POOL        = 4;
    localparam int DRAIN_CYC   = 60;
    localparam int LIMIT_CYC   = 600000;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE, RDY_PERIODIC} ready_mode_e;

    typedef struct {
        in_item_t           beat;
        bit                 typed;
        logic [SHADE_W-1:0] shade;
    } dir_row_t;

    logic clk;
    logic rst_n;

    dmps_stream_if #(.payload_t(in_item_t))  pixels ();
    dmps_stream_if #(.payload_t(out_item_t)) shades ();

    dot_matrix_pwm_shade_fir dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .shades (shades)
    );

    // shadow of the frame history and per-display ring pointers
    bit [7:0]    frame_hist [DISPLAYS][HIST_FRAMES][BYTES_PER_FRAME];
    int unsigned ring_slot [DISPLAYS];

    out_item_t   shade_q [$];
    dir_row_t    dir_rows [DIR_ROWS];

    int unsigned n_errors;
    int unsigned n_beats;
    int unsigned n_frame_ends;
    int unsigned n_checked;
    int unsigned n_full_shade;
    int unsigned burst_left;

    logic [BYTE_W-1:0] pool_addr [DISPLAYS][POOL];
    logic [7:0]        pool_pat  [DISPLAYS][POOL];

    ready_mode_e rdy_mode;
    int unsigned rdy_left;
    int unsigned rdy_period;
    int unsigned rdy_phase;

    out_item_t                     mon_exp;
    logic [$bits(out_item_t)-1:0]  mon_gv;
    logic [$bits(out_item_t)-1:0]  mon_ev;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(LIMIT_CYC * 12);
        $display("timeout: %0d shade beats still outstanding", shade_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report(input string msg);
        n_errors++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    function automatic out_item_t predict_shades(input in_item_t it);
        int unsigned d;
        int unsigned s;
        int unsigned f;
        int unsigned t;
        int unsigned p;
        logic [7:0]  b;
        int unsigned acc [PIXELS];
        logic [SHADE_W-1:0] sh [PIXELS];
        out_item_t   r;
        d = it.display_select;
        if (d >= DISPLAYS)
            d = DISPLAYS - 1;
        s = ring_slot[d];
        frame_hist[d][s][it.byte_index] = it.pixel_byte;
        for (p = 0; p < PIXELS; p++)
            acc[p] = 0;
        // tap 0 is the frame being written, older frames walk back around the ring
        for (t = 0; t < TAP_COUNT; t++)
        begin
            f = (s + HIST_FRAMES - (t % HIST_FRAMES)) % HIST_FRAMES;
            b = frame_hist[d][f][it.byte_index];
            for (p = 0; p < PIXELS; p++)
                if (b[7 - p])
                    acc[p] += TAP_WEIGHT[t];
        end
        for (p = 0; p < PIXELS; p++)
            sh[p] = SHADE_W'(((SHADE_SCALE * acc[p]) / WEIGHT_SUM) >> SHADE_SHIFT);
        r.out_byte_index = BYTE_W'(it.byte_index % BYTES_PER_FRAME);
        r.shade_0 = sh[0];
        r.shade_1 = sh[1];
        r.shade_2 = sh[2];
        r.shade_3 = sh[3];
        r.shade_4 = sh[4];
        r.shade_5 = sh[5];
        r.shade_6 = sh[6];
        r.shade_7 = sh[7];
        if (it.frame_end)
            ring_slot[d] = (s + 1) % HIST_FRAMES;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input bit d, input int idx, input logic [7:0] pix,
                                        input bit fend, input bit typed,
                                        input logic [SHADE_W-1:0] shade);
        dir_row_t row;
        row.beat.display_select = d;
        row.beat.byte_index     = BYTE_W'(idx);
        row.beat.pixel_byte     = pix;
        row.beat.frame_end      = fend;
        row.typed               = typed;
        row.shade               = shade;
        return row;
    endfunction

    // sender: bursts of back-to-back beats separated by random idle gaps
    task automatic push_beat(input in_item_t it, input bit typed,
                             input logic [SHADE_W-1:0] shade);
        int unsigned gap;
        out_item_t   e;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            burst_left = $urandom_range(1, 20);
            if (gap != 0)
            begin
                pixels.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pixels.valid <= 1'b1;
        pixels.data  <= it;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        e = predict_shades(it);
        if (typed)
        begin
            e.out_byte_index = it.byte_index;
            e.shade_0 = shade;
            e.shade_1 = shade;
            e.shade_2 = shade;
            e.shade_3 = shade;
            e.shade_4 = shade;
            e.shade_5 = shade;
            e.shade_6 = shade;
            e.shade_7 = shade;
        end
        shade_q.push_back(e);
        burst_left--;
        n_beats++;
        if (it.frame_end)
            n_frame_ends++;
    endtask

    // receiver: ready pattern picks a new random mode after each random-length run
    initial begin
        shades.ready = 1'b0;
        rdy_left     = 0;
        rdy_phase    = 0;
        forever
        begin
            @(posedge clk);
            if (rdy_left == 0)
            begin
                rdy_mode   = ready_mode_e'($urandom_range(0, 3));
                rdy_left   = $urandom_range(30, 300);
                rdy_period = $urandom_range(2, 9);
            end
            rdy_left--;
            rdy_phase++;
            case (rdy_mode)
                RDY_ALWAYS:   shades.ready <= 1'b1;
                RDY_RANDOM:   shades.ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE:   shades.ready <= ($urandom_range(0, 3) == 0);
                RDY_PERIODIC: shades.ready <= (((rdy_phase / rdy_period) % 2) == 0);
                default:      shades.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && shades.valid && shades.ready)
        begin
            if (shade_q.size() == 0)
                report($sformatf("shade beat for byte %0d with nothing expected",
                                 shades.data.out_byte_index));
            else
            begin
                mon_exp = shade_q.pop_front();
                mon_gv  = shades.data;
                mon_ev  = mon_exp;
                n_checked++;
                if (shades.data.out_byte_index !== mon_exp.out_byte_index)
                    report($sformatf("out_byte_index got %0d exp %0d",
                                     shades.data.out_byte_index, mon_exp.out_byte_index));
                for (int p = 0; p < PIXELS; p++)
                begin
                    if (mon_gv[(7 - p) * SHADE_W +: SHADE_W] !==
                        mon_ev[(7 - p) * SHADE_W +: SHADE_W])
                        report($sformatf("byte %0d shade_%0d got %0d exp %0d",
                                         mon_exp.out_byte_index, p,
                                         mon_gv[(7 - p) * SHADE_W +: SHADE_W],
                                         mon_ev[(7 - p) * SHADE_W +: SHADE_W]));
                    if (mon_ev[(7 - p) * SHADE_W +: SHADE_W] == SHADE_W'(SHADE_LEVELS - 1))
                        n_full_shade++;
                end
            end
        end
    end

    initial begin
        in_item_t    it;
        int unsigned d;
        int unsigned k;
        int unsigned j;
        int unsigned sel;

        rst_n        = 1'b0;
        pixels.valid = 1'b0;
        pixels.data  = '0;
        n_errors     = 0;
        n_beats      = 0;
        n_frame_ends = 0;
        n_checked    = 0;
        n_full_shade = 0;
        burst_left   = 0;
        for (int i = 0; i < DISPLAYS; i++)
            ring_slot[i] = 0;

        // fresh history: only the tap-0 weight of 8 can count, far below shade 1
        dir_rows[0]  = mk_row(1'b0,   0, 8'hFF, 1'b0, 1'b1, 4'd0);
        dir_rows[1]  = mk_row(1'b1, 511, 8'hFF, 1'b0, 1'b1, 4'd0);
        dir_rows[2]  = mk_row(1'b0, 511, 8'h00, 1'b0, 1'b1, 4'd0);
        dir_rows[3]  = mk_row(1'b1,   0, 8'h80, 1'b0, 1'b1, 4'd0);
        dir_rows[4]  = mk_row(1'b0,   0, 8'hFF, 1'b1, 1'b1, 4'd0);
        dir_rows[5]  = mk_row(1'b0,   0, 8'hFF, 1'b1, 1'b0, 4'd0);
        dir_rows[6]  = mk_row(1'b0,   0, 8'hFF, 1'b1, 1'b0, 4'd0);
        dir_rows[7]  = mk_row(1'b0,   0, 8'hFF, 1'b1, 1'b0, 4'd0);
        // display 1 pointer still at slot 0
        dir_rows[8]  = mk_row(1'b1, 511, 8'hAA, 1'b1, 1'b0, 4'd0);
        dir_rows[9]  = mk_row(1'b1, 511, 8'h55, 1'b1, 1'b0, 4'd0);
        dir_rows[10] = mk_row(1'b1, 511, 8'hAA, 1'b1, 1'b0, 4'd0);
        dir_rows[11] = mk_row(1'b0, 256, 8'h01, 1'b0, 1'b0, 4'd0);
        dir_rows[12] = mk_row(1'b0, 255, 8'hFE, 1'b1, 1'b0, 4'd0);
        dir_rows[13] = mk_row(1'b1, 256, 8'h7F, 1'b0, 1'b0, 4'd0);
        dir_rows[14] = mk_row(1'b0,   0, 8'h00, 1'b0, 1'b0, 4'd0);
        dir_rows[15] = mk_row(1'b0,   0, 8'hFF, 1'b1, 1'b0, 4'd0);
        dir_rows[16] = mk_row(1'b1, 170, 8'hF0, 1'b1, 1'b0, 4'd0);
        dir_rows[17] = mk_row(1'b1, 341, 8'h0F, 1'b0, 1'b0, 4'd0);
        dir_rows[18] = mk_row(1'b1, 511, 8'hFF, 1'b1, 1'b0, 4'd0);
        dir_rows[19] = mk_row(1'b0, 511, 8'hFF, 1'b1, 1'b0, 4'd0);

        for (int i = 0; i < DISPLAYS; i++)
            for (int q = 0; q < POOL; q++)
            begin
                pool_addr[i][q] = BYTE_W'($urandom_range(0, BYTES_PER_FRAME - 1));
                pool_pat[i][q]  = 8'($urandom_range(0, 255));
            end
        pool_addr[0][0] = '0;
        pool_addr[1][POOL-1] = BYTE_W'(BYTES_PER_FRAME - 1);
        pool_pat[0][1] = 8'hFF;
        pool_pat[1][0] = 8'hFF;
        pool_pat[1][2] = 8'h00;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // pixels stays not ready through the history clear
        for (int i = 0; i < DIR_ROWS; i++)
            push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].shade);

        // mostly short frames over a small address pool with steady patterns, so the
        // filter fills up and the ring wraps many times; the rest is noise
        while (n_beats < BEAT_TARGET)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 8)
            begin
                d = $urandom_range(0, 1);
                k = $urandom_range(1, POOL);
                if ($urandom_range(0, 29) == 0)
                begin
                    j = $urandom_range(0, POOL - 1);
                    pool_addr[d][j] = BYTE_W'($urandom_range(0, BYTES_PER_FRAME - 1));
                    pool_pat[d][j]  = 8'($urandom_range(0, 255));
                end
                for (j = 0; j < k; j++)
                begin
                    it.display_select = 1'(d);
                    it.byte_index     = pool_addr[d][j];
                    it.pixel_byte     = pool_pat[d][j];
                    if ($urandom_range(0, 7) == 0)
                        it.pixel_byte[$urandom_range(0, 7)] ^= 1'b1;
                    if (sel == 7)
                        it.pixel_byte = 8'($urandom_range(0, 255));
                    // occasionally a frame is left open
                    it.frame_end = (j == k - 1) && ($urandom_range(0, 9) != 0);
                    push_beat(it, 1'b0, '0);
                end
            end
            else
            begin
                it.display_select = 1'($urandom_range(0, 1));
                it.byte_index     = BYTE_W'($urandom_range(0, BYTES_PER_FRAME - 1));
                it.pixel_byte     = 8'($urandom_range(0, 255));
                it.frame_end      = ($urandom_range(0, 3) == 0);
                push_beat(it, 1'b0, '0);
            end
        end

        pixels.valid <= 1'b0;
        while (shade_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Sent %0d pixel beats with %0d frame ends over both displays",
                 n_beats, n_frame_ends);
        $display("Checked %0d shade beats, %0d pixels expected at full shade",
                 n_checked, n_full_shade);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dmps_pkg.sv
hdl/dmps_stream_if.sv
hdl/dmps_ram.sv
hdl/dot_matrix_pwm_shade_fir.sv
tb/dot_matrix_pwm_shade_fir_tb.sv
